// ----- rtl/stc_pkg.sv -----
// ----------------------------------------------------------------------------
// stc_pkg - shared constants and types of the pair combiner
// Field widths and the status flags handed along the divider chain.
// ----------------------------------------------------------------------------
package stc_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int GAIN_BITS   = 18;
  localparam int LANES       = 4;

  // per-beat status that travels beside the data
  typedef struct packed {
    logic [LANES-1:0] neg;   // numerator of each lane is negative
    logic             zero;  // gain was zero
  } stc_flags_t;

endpackage

// ----- rtl/stc_front.sv -----
// ----------------------------------------------------------------------------
// stc_front - products and numerators
// Stage one registers the sixteen cross products, stage two the four sums,
// taken apart into magnitude and sign.
// ----------------------------------------------------------------------------
module stc_front #(
  parameter int SAMPLE_BITS = stc_pkg::SAMPLE_BITS
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [7:0][SAMPLE_BITS-1:0]           in_smp,
  input  logic [stc_pkg::GAIN_BITS-1:0]         in_gain,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [stc_pkg::LANES-1:0][2*SAMPLE_BITS:0] out_mag,
  output logic [stc_pkg::GAIN_BITS-1:0]         out_gain,
  output stc_pkg::stc_flags_t                   out_flags
);

  localparam int PW = 2*SAMPLE_BITS;
  localparam int SW = 2*SAMPLE_BITS + 2;
  localparam int MW = 2*SAMPLE_BITS + 1;

  logic signed [SAMPLE_BITS-1:0] r0r, r0i, r1r, r1i, h0r, h0i, h1r, h1i;
  logic signed [15:0][PW-1:0]    prod_next;
  logic signed [PW-1:0]          prod [16];
  logic [stc_pkg::GAIN_BITS-1:0] gain1;
  logic                          v1;
  logic                          rdy1;
  logic signed [SW-1:0]          sum [stc_pkg::LANES];
  logic [stc_pkg::LANES-1:0][MW-1:0] mag_next;
  logic [stc_pkg::LANES-1:0]     neg_next;

  assign r0r = in_smp[0];
  assign r0i = in_smp[1];
  assign r1r = in_smp[2];
  assign r1i = in_smp[3];
  assign h0r = in_smp[4];
  assign h0i = in_smp[5];
  assign h1r = in_smp[6];
  assign h1i = in_smp[7];

  always_comb begin
    prod_next[0]  = h0r * r0r;
    prod_next[1]  = h0i * r0i;
    prod_next[2]  = h1r * r1r;
    prod_next[3]  = h1i * r1i;
    prod_next[4]  = h0r * r0i;
    prod_next[5]  = h0i * r0r;
    prod_next[6]  = h1r * r1i;
    prod_next[7]  = h1i * r1r;
    prod_next[8]  = h1r * r0r;
    prod_next[9]  = h1i * r0i;
    prod_next[10] = h0r * r1r;
    prod_next[11] = h0i * r1i;
    prod_next[12] = h1r * r0i;
    prod_next[13] = h1i * r0r;
    prod_next[14] = h0r * r1i;
    prod_next[15] = h0i * r1r;
  end

  assign rdy1     = !out_valid || out_ready;
  assign in_ready = !v1 || rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (in_ready) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      for (int i = 0; i < 16; i++) prod[i] <= prod_next[i];
      gain1 <= in_gain;
    end
  end

  // sign pattern of the combining, r1 taken without conjugation
  always_comb begin
    sum[0] = SW'(prod[0])  + SW'(prod[1])  + SW'(prod[2])  - SW'(prod[3]);
    sum[1] = SW'(prod[4])  - SW'(prod[5])  + SW'(prod[6])  + SW'(prod[7]);
    sum[2] = SW'(prod[8])  + SW'(prod[9])  - SW'(prod[10]) + SW'(prod[11]);
    sum[3] = SW'(prod[12]) - SW'(prod[13]) - SW'(prod[14]) - SW'(prod[15]);
    for (int l = 0; l < stc_pkg::LANES; l++) begin
      neg_next[l] = sum[l][SW-1];
      mag_next[l] = sum[l][SW-1] ? MW'(-sum[l]) : MW'(sum[l]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rdy1) begin
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (v1 && rdy1) begin
      out_mag        <= mag_next;
      out_gain       <= gain1;
      out_flags.neg  <= neg_next;
      out_flags.zero <= (gain1 == '0);
    end
  end

endmodule

// ----- rtl/stc_div_cell.sv -----
// ----------------------------------------------------------------------------
// stc_div_cell - one restoring division step
// Decides quotient bit SHIFT for all four lanes and passes the remainder on.
// ----------------------------------------------------------------------------
module stc_div_cell #(
  parameter int SAMPLE_BITS = stc_pkg::SAMPLE_BITS,
  parameter int SHIFT       = 0
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [stc_pkg::LANES-1:0][2*SAMPLE_BITS:0] in_rem,
  input  logic [stc_pkg::LANES-1:0][SAMPLE_BITS:0]   in_quo,
  input  logic [stc_pkg::GAIN_BITS-1:0]         in_gain,
  input  stc_pkg::stc_flags_t                   in_flags,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [stc_pkg::LANES-1:0][2*SAMPLE_BITS:0] out_rem,
  output logic [stc_pkg::LANES-1:0][SAMPLE_BITS:0]   out_quo,
  output logic [stc_pkg::GAIN_BITS-1:0]         out_gain,
  output stc_pkg::stc_flags_t                   out_flags
);

  localparam int MW = 2*SAMPLE_BITS + 1;
  localparam int CW = MW + stc_pkg::GAIN_BITS;

  logic [CW-1:0]                             dvs;
  logic [stc_pkg::LANES-1:0][MW-1:0]         rem_next;
  logic [stc_pkg::LANES-1:0][SAMPLE_BITS:0]  quo_next;

  always_comb begin
    logic [CW-1:0] rv;
    dvs = CW'(in_gain) << SHIFT;
    for (int l = 0; l < stc_pkg::LANES; l++) begin
      rv          = CW'(in_rem[l]);
      quo_next[l] = in_quo[l];
      if (rv >= dvs) begin
        rem_next[l]        = MW'(rv - dvs);
        quo_next[l][SHIFT] = 1'b1;
      end else begin
        rem_next[l]        = in_rem[l];
        quo_next[l][SHIFT] = 1'b0;
      end
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_rem   <= rem_next;
      out_quo   <= quo_next;
      out_gain  <= in_gain;
      out_flags <= in_flags;
    end
  end

endmodule

// ----- rtl/stc_round.sv -----
// ----------------------------------------------------------------------------
// stc_round - rounding, saturation, zero-gain blanking and output register
// Rounds half away from zero, clamps to the sample range, restores the sign.
// ----------------------------------------------------------------------------
module stc_round #(
  parameter int SAMPLE_BITS = stc_pkg::SAMPLE_BITS
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [stc_pkg::LANES-1:0][2*SAMPLE_BITS:0] in_rem,
  input  logic [stc_pkg::LANES-1:0][SAMPLE_BITS:0]   in_quo,
  input  logic [stc_pkg::GAIN_BITS-1:0]         in_gain,
  input  stc_pkg::stc_flags_t                   in_flags,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [stc_pkg::LANES-1:0][SAMPLE_BITS-1:0] out_sym,
  output logic                                  out_zero
);

  localparam int MW = 2*SAMPLE_BITS + 1;
  localparam int CW = MW + stc_pkg::GAIN_BITS;
  localparam int QW = SAMPLE_BITS + 2;

  logic [stc_pkg::LANES-1:0][SAMPLE_BITS-1:0] sym_next;

  always_comb begin
    logic          rnd;
    logic [QW-1:0] q;
    logic [QW-1:0] lim;
    for (int l = 0; l < stc_pkg::LANES; l++) begin
      rnd = ({CW'(in_rem[l]), 1'b0} >= {1'b0, CW'(in_gain)});
      q   = QW'(in_quo[l]) + QW'(rnd);
      lim = in_flags.neg[l] ? (QW'(1) << (SAMPLE_BITS-1))
                            : ((QW'(1) << (SAMPLE_BITS-1)) - QW'(1));
      // top quotient bit means the magnitude is far past the range
      if (in_quo[l][SAMPLE_BITS] || (q > lim)) q = lim;
      if (in_flags.zero) begin
        sym_next[l] = '0;
      end else if (in_flags.neg[l]) begin
        sym_next[l] = SAMPLE_BITS'(~q + QW'(1));
      end else begin
        sym_next[l] = SAMPLE_BITS'(q);
      end
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_sym  <= sym_next;
      out_zero <= in_flags.zero;
    end
  end

endmodule

// ----- rtl/space_time_pair_combiner_unit.sv -----
// ----------------------------------------------------------------------------
// space_time_pair_combiner_unit - 2x1 space-time pair combiner
// Two product/sum stages, a row of SAMPLE_BITS+1 divider cells, one quotient
// bit each, and one rounding stage. Throughput one symbol pair per cycle;
// each stage holds its beat on backpressure and bubbles close up.
// Synchronous reset clears the valid flags only; nothing else needs clearing.
// ----------------------------------------------------------------------------
module space_time_pair_combiner_unit #(
  parameter int SAMPLE_BITS = stc_pkg::SAMPLE_BITS
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // rx0_re, rx0_im, rx1_re, rx1_im, chan0_re, chan0_im, chan1_re, chan1_im,
  // pair_gain, zero pad
  input  logic [((8*SAMPLE_BITS+stc_pkg::GAIN_BITS+7)/8)*8-1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // sym0_re, sym0_im, sym1_re, sym1_im, zero pad
  output logic [((4*SAMPLE_BITS+7)/8)*8-1:0] m_axis_tdata,
  // zero_gain
  output logic [0:0] m_axis_tuser
);

  localparam int NC  = SAMPLE_BITS + 1;
  localparam int MW  = 2*SAMPLE_BITS + 1;
  localparam int OW  = ((4*SAMPLE_BITS+7)/8)*8;
  localparam int GB  = stc_pkg::GAIN_BITS;
  localparam int LN  = stc_pkg::LANES;

  logic [7:0][SAMPLE_BITS-1:0] smp;
  logic [GB-1:0]               gain;

  logic [NC:0]                 cv;
  logic [NC:0]                 cr;
  logic [LN-1:0][MW-1:0]       crem  [NC+1];
  logic [LN-1:0][SAMPLE_BITS:0] cquo [NC+1];
  logic [GB-1:0]               cgain [NC+1];
  stc_pkg::stc_flags_t         cflg  [NC+1];

  logic [LN-1:0][SAMPLE_BITS-1:0] sym;
  logic                           zg;

  assign smp  = s_axis_tdata[8*SAMPLE_BITS-1:0];
  assign gain = s_axis_tdata[8*SAMPLE_BITS +: GB];

  stc_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_smp    (smp),
    .in_gain   (gain),
    .out_valid (cv[0]),
    .out_ready (cr[0]),
    .out_mag   (crem[0]),
    .out_gain  (cgain[0]),
    .out_flags (cflg[0])
  );

  assign cquo[0] = '0;

  for (genvar j = 0; j < NC; j++) begin : g_cell
    stc_div_cell #(.SAMPLE_BITS(SAMPLE_BITS), .SHIFT(SAMPLE_BITS - j)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (cv[j]),
      .in_ready  (cr[j]),
      .in_rem    (crem[j]),
      .in_quo    (cquo[j]),
      .in_gain   (cgain[j]),
      .in_flags  (cflg[j]),
      .out_valid (cv[j+1]),
      .out_ready (cr[j+1]),
      .out_rem   (crem[j+1]),
      .out_quo   (cquo[j+1]),
      .out_gain  (cgain[j+1]),
      .out_flags (cflg[j+1])
    );
  end

  stc_round #(.SAMPLE_BITS(SAMPLE_BITS)) u_round (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cv[NC]),
    .in_ready  (cr[NC]),
    .in_rem    (crem[NC]),
    .in_quo    (cquo[NC]),
    .in_gain   (cgain[NC]),
    .in_flags  (cflg[NC]),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_sym   (sym),
    .out_zero  (zg)
  );

  assign m_axis_tdata = OW'(sym);
  assign m_axis_tuser = zg;

  // a zero-gain beat carries all-zero symbols
  a_zero_out: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
    else $error("zero-gain beat with non-zero symbols");

  // input only stalls when the whole chain is full and output is blocked
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (&cv) && m_axis_tvalid && !m_axis_tready)
    else $error("input stalled with room in the chain");

  // output empty after reset
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid straight after reset");

endmodule

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench - pair combiner stream test
// Drives symbol pairs through the combiner under varied idling and back
// pressure and checks every output beat against an in-bench model.
// ----------------------------------------------------------------------------
module testbench;

  localparam int SB = stc_pkg::SAMPLE_BITS;
  localparam int GAIN_BITS = stc_pkg::GAIN_BITS;
  localparam int IN_W = ((8*SB+GAIN_BITS+7)/8)*8;
  localparam int OUT_W = ((4*SB+7)/8)*8;
  localparam int LATENCY = SB + 4;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct {
    logic signed [SB-1:0] r0r, r0i, r1r, r1i, h0r, h0i, h1r, h1i;
    logic [GAIN_BITS-1:0] gain;
  } pair_t;

  typedef struct {
    logic [SB-1:0] s0r, s0i, s1r, s1i;
    logic          zg;
  } combined_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;
  logic [0:0] m_axis_tuser;

  int errors = 0;
  longint cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_off = 0;

  space_time_pair_combiner_unit dut (.*);

  task automatic report(input string what);
    errors++;
    $display("mismatch: %s", what);
  endtask

  // one quotient lane: exact sum, round half away from zero, saturate
  function automatic logic [SB-1:0] lane_div(input logic signed [63:0] num,
                                             input logic [GAIN_BITS-1:0] g);
    logic [63:0] mag, q, r, lim;
    logic neg;
    neg = num < 0;
    mag = neg ? -num : num;
    lim = neg ? (64'd1 << (SB-1)) : ((64'd1 << (SB-1)) - 1);
    q = mag / g;
    r = mag % g;
    if (r >= g - r) q++;
    if (q > lim) q = lim;
    return neg ? -q[SB-1:0] : q[SB-1:0];
  endfunction

  function automatic combined_t combine_pair(input pair_t p);
    combined_t c;
    logic signed [63:0] a, b, d, e, f, h, k, l;
    c = '{default: '0};
    if (p.gain == 0) begin
      c.zg = 1'b1;
      return c;
    end
    a = p.r0r; b = p.r0i; d = p.r1r; e = p.r1i;
    f = p.h0r; h = p.h0i; k = p.h1r; l = p.h1i;
    c.s0r = lane_div(f*a + h*b + k*d - l*e, p.gain);
    c.s0i = lane_div(f*b - h*a + k*e + l*d, p.gain);
    c.s1r = lane_div(k*a + l*b - f*d + h*e, p.gain);
    c.s1i = lane_div(k*b - l*a - f*e - h*d, p.gain);
    return c;
  endfunction

  class combiner_scoreboard;
    combined_t pending[$];
    function void note_pair(pair_t p);
      pending.push_back(combine_pair(p));
    endfunction
    task check_beat(logic [OUT_W-1:0] d, logic zg);
      combined_t e;
      if (pending.size() == 0) begin
        report("output beat with nothing expected");
        return;
      end
      e = pending.pop_front();
      if (d[SB-1:0] !== e.s0r) report($sformatf("sym0_re %h exp %h", d[SB-1:0], e.s0r));
      if (d[2*SB-1:SB] !== e.s0i) report($sformatf("sym0_im %h exp %h", d[2*SB-1:SB], e.s0i));
      if (d[3*SB-1:2*SB] !== e.s1r)
        report($sformatf("sym1_re %h exp %h", d[3*SB-1:2*SB], e.s1r));
      if (d[4*SB-1:3*SB] !== e.s1i)
        report($sformatf("sym1_im %h exp %h", d[4*SB-1:3*SB], e.s1i));
      if (zg !== e.zg) report($sformatf("zero_gain %b exp %b", zg, e.zg));
    endtask
  endclass

  combiner_scoreboard board = new();

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // output side: sample on rising edge, change ready on falling edge
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) board.check_beat(m_axis_tdata, m_axis_tuser[0]);
  end

  always @(negedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // valid stays up between beats; it only drops while the sender idles
  task automatic send_pair(input pair_t p);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= IN_W'({p.gain, p.h1i, p.h1r, p.h0i, p.h0r, p.r1i, p.r1r, p.r0i, p.r0r});
    do @(posedge clk); while (!s_axis_tready);
    board.note_pair(p);
    @(negedge clk);
  endtask

  function automatic logic signed [SB-1:0] rand_sample();
    case ($urandom_range(5))
      0: return {1'b1, {(SB-1){1'b0}}};
      1: return {1'b0, {(SB-1){1'b1}}};
      2: return SB'($urandom_range(8191)) - SB'(4096);
      default: return SB'($urandom);
    endcase
  endfunction

  function automatic pair_t rand_pair();
    pair_t p;
    p.r0r = rand_sample(); p.r0i = rand_sample();
    p.r1r = rand_sample(); p.r1i = rand_sample();
    p.h0r = rand_sample(); p.h0i = rand_sample();
    p.h1r = rand_sample(); p.h1i = rand_sample();
    case ($urandom_range(9))
      0: p.gain = '0;
      1: p.gain = GAIN_BITS'($urandom_range(3));
      2: p.gain = '1;
      3, 4: p.gain = GAIN_BITS'($urandom_range(262143));
      // moderate: gain drawn from 1 to 65537
      default: p.gain = GAIN_BITS'($urandom_range(1 << 16) + 1);
    endcase
    return p;
  endfunction

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (LATENCY) @(negedge clk);
  endtask

  pair_t p;
  logic signed [SB-1:0] mx, mn;

  initial begin
    mx = {1'b0, {(SB-1){1'b1}}};
    mn = {1'b1, {(SB-1){1'b0}}};
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: extremes, zero gain, unit gain, tie rounding, saturation
    p = '{mx, mx, mx, mx, mx, mx, mx, mx, 18'd1};        send_pair(p);
    p = '{mn, mn, mn, mn, mn, mn, mn, mn, 18'd1};        send_pair(p);
    p = '{mn, mn, mn, mn, mn, mn, mn, mn, '1};           send_pair(p);
    p = '{mx, mn, mx, mn, mn, mx, mn, mx, '1};           send_pair(p);
    p = '{mx, mx, mx, mx, mx, mx, mx, mx, 18'd0};        send_pair(p);
    p = '{16'd4096, 0, 0, 0, 16'd4096, 0, 0, 0, 18'd4096}; send_pair(p);
    p = '{0, 16'd4096, 0, 0, 0, 0, 16'd4096, 0, 18'd4096}; send_pair(p);
    p = '{0, 0, 16'd4096, 0, 0, 0, 0, 16'd4096, 18'd4096}; send_pair(p);
    p = '{0, 0, 0, 16'd4096, 0, 16'd4096, 0, 0, 18'd4096}; send_pair(p);
    p = '{16'd1, 0, 0, 0, 16'd1, 0, 0, 0, 18'd2};        send_pair(p); // tie up
    p = '{-16'sd1, 0, 0, 0, 16'd1, 0, 0, 0, 18'd2};      send_pair(p); // tie down
    p = '{16'd1, 0, 0, 0, 16'd1, 0, 0, 0, 18'd3};        send_pair(p);
    p = '{0, 0, 0, 0, 0, 0, 0, 0, 18'd1};                send_pair(p);
    p = '{mx, 0, 0, 0, mx, 0, 0, 0, 18'd2};              send_pair(p);
    p = '{mn, 0, 0, 0, mx, 0, 0, 0, 18'd2};              send_pair(p);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 63 : 21) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 63 : 21) : 0;
      if (ph == 0) hold_off = 300; // fill the pipe and stall the input
      for (int i = 0; i < 200; i++) send_pair(rand_pair());
      drain(); // sender waits for every outstanding result
    end

    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/stc_pkg.sv
rtl/stc_front.sv
rtl/stc_div_cell.sv
rtl/stc_round.sv
rtl/space_time_pair_combiner_unit.sv
test/testbench.sv
